### sv/sts_pkg.sv
// Shared types and constants for the script token scanner.
// Word structs for both channels, scan mode codes, token kinds, keyword table.
// No dependencies.
`default_nettype none

package sts_pkg;

    // input word: one source byte or the end mark
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_word_t;

    // output word: one token
    typedef struct packed {
        logic [5:0] token_kind;
        logic [7:0] token_length;
        logic       last;
    } out_word_t;

    // tokens produced by one accepted input word (0, 1 or 2)
    typedef struct packed {
        logic [1:0]      cnt;
        out_word_t [1:0] tok;
    } tok_push_t;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_WORD    = 3'd1,
        M_NUMBER  = 3'd2,
        M_STRING  = 3'd3,
        M_COMMENT = 3'd4,
        M_SKIP    = 3'd5,
        M_DOT     = 3'd6,
        M_OPER    = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        P_NONE = 3'd0,
        P_EQ   = 3'd1,
        P_GT   = 3'd2,
        P_LT   = 3'd3,
        P_EXCL = 3'd4
    } pend_t;

    // token kinds
    localparam logic [5:0] K_ID     = 6'd0;
    localparam logic [5:0] K_PLUS   = 6'd13;
    localparam logic [5:0] K_MINUS  = 6'd14;
    localparam logic [5:0] K_STAR   = 6'd15;
    localparam logic [5:0] K_SLASH  = 6'd16;
    localparam logic [5:0] K_DOT    = 6'd17;
    localparam logic [5:0] K_COMMA  = 6'd18;
    localparam logic [5:0] K_SEMI   = 6'd19;
    localparam logic [5:0] K_LPAR   = 6'd20;
    localparam logic [5:0] K_RPAR   = 6'd21;
    localparam logic [5:0] K_LBRACE = 6'd22;
    localparam logic [5:0] K_RBRACE = 6'd23;
    localparam logic [5:0] K_LBRACK = 6'd24;
    localparam logic [5:0] K_RBRACK = 6'd25;
    localparam logic [5:0] K_PIPE   = 6'd26;
    localparam logic [5:0] K_AMP    = 6'd27;
    localparam logic [5:0] K_CARET  = 6'd28;
    localparam logic [5:0] K_DOLLAR = 6'd29;
    localparam logic [5:0] K_COLON  = 6'd30;
    localparam logic [5:0] K_AFF    = 6'd31;
    localparam logic [5:0] K_EQ     = 6'd32;
    localparam logic [5:0] K_GT     = 6'd33;
    localparam logic [5:0] K_GE     = 6'd34;
    localparam logic [5:0] K_LT     = 6'd35;
    localparam logic [5:0] K_LE     = 6'd36;
    localparam logic [5:0] K_EXCL   = 6'd37;
    localparam logic [5:0] K_DIFF   = 6'd38;
    localparam logic [5:0] K_NUMBER = 6'd39;
    localparam logic [5:0] K_STRING = 6'd40;
    localparam logic [5:0] K_EOF    = 6'd41;
    localparam logic [5:0] K_ERROR  = 6'd42;

    localparam logic [7:0] EOF_LEN = 8'd3;

    // characters with a role of their own
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword table; text held byte 0 in the low bits, zero padded to 8 bytes
    localparam int NUM_KW = 13;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("EURT"), 64'("ESLAF"), 64'("elihw"), 64'("noitcnuf"),
        64'("nruter"), 64'("fi"), 64'("esle"), 64'("taeper"),
        64'("rof"), 64'("ni"), 64'("tsil"), 64'("c"), 64'("tnirp")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd5, 4'd5, 4'd8, 4'd6, 4'd2, 4'd4, 4'd6, 4'd3, 4'd2, 4'd4, 4'd1, 4'd5
    };
    localparam logic [5:0] KW_KIND [NUM_KW] = '{
        6'd1, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12
    };

    // token queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int OUT_CW    = 3;

endpackage

`default_nettype wire

### sv/sts_scan.sv
// Scanner core: scan state registers and the per-character next-state logic.
// Produces up to two tokens per accepted word. Depends on sts_pkg.
`default_nettype none

module sts_scan
    import sts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int KEYWORD_CHARS = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire in_word_t  in_word,
    output tok_push_t      push
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int EW = (LW > 8) ? LW : 8;

    mode_t                           mode_reg, mode_next;
    logic [KEYWORD_CHARS-1:0][7:0]   prefix_reg, prefix_next;
    logic [LW-1:0]                   len_reg, len_next;
    logic                            dot_reg, dot_next;
    pend_t                           pend_reg, pend_next;

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_number_end(input logic [7:0] ch);
        return (ch == 8'h2B) || (ch == 8'h2A) || (ch == 8'h2D) || (ch == 8'h3C)
            || (ch == 8'h3E) || (ch == 8'h2F) || (ch == 8'h3B) || (ch == 8'h29)
            || (ch == 8'h7D) || (ch == 8'h2C) || (ch == 8'h5D) || (ch == 8'h5E)
            || (ch == 8'h3A) || (ch == 8'h21) || (ch == 8'h3D);
    endfunction

    // {valid, kind} for single-character operators
    function automatic logic [6:0] single_kind(input logic [7:0] ch);
        logic [6:0] r;
        r = {1'b0, K_ERROR};
        unique case (ch)
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2A:   r = {1'b1, K_STAR};
            8'h2F:   r = {1'b1, K_SLASH};
            8'h2C:   r = {1'b1, K_COMMA};
            8'h3B:   r = {1'b1, K_SEMI};
            8'h28:   r = {1'b1, K_LPAR};
            8'h29:   r = {1'b1, K_RPAR};
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            8'h5B:   r = {1'b1, K_LBRACK};
            8'h5D:   r = {1'b1, K_RBRACK};
            8'h7C:   r = {1'b1, K_PIPE};
            8'h26:   r = {1'b1, K_AMP};
            8'h5E:   r = {1'b1, K_CARET};
            8'h24:   r = {1'b1, K_DOLLAR};
            8'h3A:   r = {1'b1, K_COLON};
            default: r = {1'b0, K_ERROR};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic [LW-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        return (e > EW'(255)) ? 8'hFF : e[7:0];
    endfunction

    logic [7:0]                    c;
    logic [LW-1:0]                 len_inc;
    logic [5:0]                    word_kind;
    logic                          kw_hit;
    logic [6:0]                    sk;
    // start of a new token from c
    mode_t                         st_mode;
    logic [KEYWORD_CHARS-1:0][7:0] st_prefix;
    logic [LW-1:0]                 st_len;
    pend_t                         st_pend;
    logic                          st_emit;
    logic [5:0]                    st_kind;
    // emission slots
    logic [5:0]                    e_kind [2];
    logic [7:0]                    e_len  [2];
    logic [1:0]                    n;
    logic                          restart;
    logic                          clear;
    logic                          to_skip;
    logic [5:0]                    pend_kind;

    always_comb
    begin
        c       = in_word.char_byte;
        len_inc = (len_reg < LW'(MAX_TOKEN_LEN)) ? len_reg + 1'b1 : len_reg;

        // keyword lookup on the stored prefix and length
        word_kind = K_ID;
        kw_hit    = 1'b0;
        for (int i = 0; i < NUM_KW; i++)
        begin
            if (!kw_hit && (len_reg == LW'(KW_LEN[i])) && (prefix_reg[7:0] == KW_TEXT[i]))
            begin
                kw_hit    = 1'b1;
                word_kind = KW_KIND[i];
            end
        end

        unique case (pend_reg)
            P_EQ:    pend_kind = K_AFF;
            P_GT:    pend_kind = K_GT;
            P_LT:    pend_kind = K_LT;
            P_EXCL:  pend_kind = K_EXCL;
            default: pend_kind = K_ERROR;
        endcase

        // what c does when it opens a token
        sk        = single_kind(c);
        st_mode   = M_IDLE;
        st_prefix = '0;
        st_len    = '0;
        st_pend   = P_NONE;
        st_emit   = 1'b0;
        st_kind   = K_ERROR;
        priority if (is_space(c))
        begin
            st_mode = M_IDLE;
        end
        else if (is_letter(c))
        begin
            st_mode      = M_WORD;
            st_prefix[0] = c;
            st_len       = LW'(1);
        end
        else if (c == CH_DOT)
        begin
            st_mode = M_DOT;
        end
        else if (is_digit(c))
        begin
            st_mode = M_NUMBER;
            st_len  = LW'(1);
        end
        else if (c == CH_HASH)
        begin
            st_mode = M_COMMENT;
        end
        else if (c == CH_QUOTE)
        begin
            st_mode = M_STRING;
        end
        else if ((c == CH_EQ) || (c == CH_GT) || (c == CH_LT) || (c == CH_EXCL))
        begin
            st_mode = M_OPER;
            priority if (c == CH_EQ) st_pend = P_EQ;
            else if (c == CH_GT)     st_pend = P_GT;
            else if (c == CH_LT)     st_pend = P_LT;
            else                     st_pend = P_EXCL;
        end
        else if (sk[6])
        begin
            st_emit = 1'b1;
            st_kind = sk[5:0];
        end
        else
        begin
            st_emit = 1'b1;
            st_kind = K_ERROR;
            st_mode = M_SKIP;
        end

        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        dot_next    = dot_reg;
        pend_next   = pend_reg;
        e_kind[0]   = K_ERROR;
        e_kind[1]   = K_ERROR;
        e_len[0]    = '0;
        e_len[1]    = '0;
        n           = 2'd0;
        restart     = 1'b0;
        clear       = 1'b0;
        to_skip     = 1'b0;

        if (in_word.end_of_input)
        begin
            n = 2'd1;
            unique case (mode_reg)
                M_WORD:   begin e_kind[0] = word_kind; e_len[0] = sat8(len_reg); end
                M_NUMBER: begin e_kind[0] = K_NUMBER;  e_len[0] = sat8(len_reg); end
                M_STRING: begin e_kind[0] = K_ERROR;   e_len[0] = sat8(len_reg); end
                M_DOT:    begin e_kind[0] = K_DOT;     e_len[0] = 8'd1; end
                M_OPER:   begin e_kind[0] = pend_kind; e_len[0] = 8'd1; end
                M_IDLE, M_COMMENT, M_SKIP: n = 2'd0;
            endcase
            e_kind[n[0]] = K_EOF;
            e_len[n[0]]  = EOF_LEN;
            n            = n + 2'd1;
            clear        = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                M_WORD:
                begin
                    if (is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT))
                    begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                        begin
                            if (len_reg == LW'(i))
                                prefix_next[i] = c;
                        end
                        len_next = len_inc;
                    end
                    else
                    begin
                        e_kind[0] = word_kind;
                        e_len[0]  = sat8(len_reg);
                        n         = 2'd1;
                        restart   = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    priority if (is_digit(c))
                    begin
                        len_next = len_inc;
                    end
                    else if (c == CH_DOT)
                    begin
                        len_next = len_inc;
                        if (dot_reg)
                        begin
                            // second dot: error, dot counted
                            e_kind[0] = K_ERROR;
                            e_len[0]  = sat8(len_inc);
                            n         = 2'd1;
                            clear     = 1'b1;
                            to_skip   = 1'b1;
                        end
                        else
                        begin
                            dot_next = 1'b1;
                        end
                    end
                    else if (is_space(c))
                    begin
                        e_kind[0] = K_NUMBER;
                        e_len[0]  = sat8(len_reg);
                        n         = 2'd1;
                        clear     = 1'b1;
                    end
                    else if (is_number_end(c))
                    begin
                        e_kind[0] = K_NUMBER;
                        e_len[0]  = sat8(len_reg);
                        n         = 2'd1;
                        restart   = 1'b1;
                    end
                    else
                    begin
                        e_kind[0] = K_ERROR;
                        e_len[0]  = sat8(len_reg);
                        n         = 2'd1;
                        clear     = 1'b1;
                        to_skip   = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        e_kind[0] = K_STRING;
                        e_len[0]  = sat8(len_reg);
                        n         = 2'd1;
                        clear     = 1'b1;
                    end
                    else
                    begin
                        len_next = len_inc;
                    end
                end
                M_COMMENT:
                begin
                    clear = (c == CH_NL);
                end
                M_SKIP:
                begin
                    clear = is_space(c);
                end
                M_DOT:
                begin
                    priority if (is_letter(c))
                    begin
                        mode_next      = M_WORD;
                        prefix_next    = '0;
                        prefix_next[0] = CH_DOT;
                        prefix_next[1] = c;
                        len_next       = LW'(2);
                        dot_next       = 1'b0;
                        pend_next      = P_NONE;
                    end
                    else if (is_digit(c))
                    begin
                        mode_next   = M_NUMBER;
                        prefix_next = '0;
                        len_next    = LW'(2);
                        dot_next    = 1'b1;
                        pend_next   = P_NONE;
                    end
                    else
                    begin
                        e_kind[0] = K_DOT;
                        e_len[0]  = 8'd1;
                        n         = 2'd1;
                        restart   = 1'b1;
                    end
                end
                M_OPER:
                begin
                    if (((c == CH_EQ) && (pend_reg != P_NONE))
                        || ((c == CH_MINUS) && (pend_reg == P_LT)))
                    begin
                        e_len[0] = 8'd2;
                        n        = 2'd1;
                        clear    = 1'b1;
                        priority if (c == CH_MINUS) e_kind[0] = K_AFF;
                        else if (pend_reg == P_EQ)  e_kind[0] = K_EQ;
                        else if (pend_reg == P_GT)  e_kind[0] = K_GE;
                        else if (pend_reg == P_LT)  e_kind[0] = K_LE;
                        else                        e_kind[0] = K_DIFF;
                    end
                    else
                    begin
                        e_kind[0] = pend_kind;
                        e_len[0]  = 8'd1;
                        n         = 2'd1;
                        restart   = 1'b1;
                    end
                end
                M_IDLE:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        if (clear)
        begin
            mode_next   = to_skip ? M_SKIP : M_IDLE;
            prefix_next = '0;
            len_next    = '0;
            dot_next    = 1'b0;
            pend_next   = P_NONE;
        end

        if (restart)
        begin
            mode_next   = st_mode;
            prefix_next = st_prefix;
            len_next    = st_len;
            dot_next    = 1'b0;
            pend_next   = st_pend;
            if (st_emit)
            begin
                e_kind[n[0]] = st_kind;
                e_len[n[0]]  = 8'd1;
                n            = n + 2'd1;
            end
        end

        push.cnt    = accept ? n : 2'd0;
        push.tok[0] = '{token_kind: e_kind[0], token_length: e_len[0], last: (n == 2'd1)};
        push.tok[1] = '{token_kind: e_kind[1], token_length: e_len[1], last: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prefix_reg <= '0;
            len_reg    <= '0;
            dot_reg    <= 1'b0;
            pend_reg   <= P_NONE;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            dot_reg    <= dot_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

### sv/sts_out_fifo.sv
// Token queue: takes up to two tokens a cycle, hands out one a cycle while stall is low.
// Depends on sts_pkg.
`default_nettype none

module sts_out_fifo
    import sts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tok_push_t push,
    output out_word_t      word,
    output logic           valid,
    input  wire logic      stall,
    output logic           no_room
);

    out_word_t             mem [OUT_DEPTH];
    logic [OUT_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OUT_CW-1:0]     count_reg, count_next;
    logic                  pop;

    assign valid   = (count_reg != '0);
    assign word    = mem[rd_ptr_reg];
    assign pop     = valid && !stall;
    // a word may bring two tokens
    assign no_room = (count_reg > OUT_CW'(OUT_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + OUT_AW'(pop);
        count_next  = count_reg + OUT_CW'(push.cnt) - OUT_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wr_ptr_reg] <= push.tok[0];
        if (push.cnt == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push.tok[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/script_token_scanner.sv
// Top level of the script token scanner: scanner core plus token queue.
// Depends on sts_pkg, sts_scan and sts_out_fifo.
//
//   channel | dir | valid       | stall       | word
//   --------+-----+-------------+-------------+----------------------------
//   chars   | in  | char_valid  | char_stall  | char_word  (in_word_t)
//   tokens  | out | token_valid | token_stall | token_word (out_word_t)
//
// One character word is taken per cycle while char_stall is low. Its tokens
// are written into a four-deep queue at the same edge and reach the token
// port in order. A character can close one token and open another,
// so char_stall rises whenever fewer than two queue slots are free; with
// token_stall low the queue drains at one token a cycle.
// Reset empties the queue and puts the scanner between tokens.
`default_nettype none

module script_token_scanner
    import sts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int KEYWORD_CHARS = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    output logic           char_stall,
    input  wire in_word_t  char_word,
    output logic           token_valid,
    input  wire logic      token_stall,
    output out_word_t      token_word
);

    logic      accept;
    tok_push_t push;
    logic      no_room;

    // the scanner only moves on an accepted character
    assign char_stall = no_room;
    assign accept     = char_valid && !no_room;

    sts_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (char_word),
        .push    (push)
    );

    sts_out_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .word    (token_word),
        .valid   (token_valid),
        .stall   (token_stall),
        .no_room (no_room)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for script_token_scanner: feeds source bytes, checks every token.
// Depends on sts_pkg (word structs, scan modes, token kinds) and the scanner RTL.
// Holds its own scanner model in a small class; plain tasks drive the character channel.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 2;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int QUIET_FROM    = 1100;     // no idling on either side past this
    localparam int HOLD_AT       = 400;      // characters sent before the long hold-off
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 12;       // queue is four deep, one token a cycle while token_stall is low
    localparam int CYCLE_LIMIT   = 400000;

    localparam int TOKEN_LEN_MAX = 255;      // saturation of the length counter
    localparam int LEN_FIELD_MAX = 255;      // saturation of token_length
    localparam int KW_CHARS      = 8;        // characters kept for keyword matching
    localparam int KW_COUNT      = 13;

    // keyword kinds; the rest of the kinds come from the package
    typedef enum logic [5:0] {
        KW_BOOL = 6'd1, KW_WHILE, KW_FUNCTION, KW_RETURN, KW_IF, KW_ELSE,
        KW_REPEAT, KW_FOR, KW_IN, KW_LIST, KW_C, KW_PRINT
    } kw_kind_e;

    string kw_spelling [KW_COUNT] = '{
        "TRUE", "FALSE", "while", "function", "return", "if", "else",
        "repeat", "for", "in", "list", "c", "print"
    };
    kw_kind_e kw_class [KW_COUNT] = '{
        KW_BOOL, KW_BOOL, KW_WHILE, KW_FUNCTION, KW_RETURN, KW_IF, KW_ELSE,
        KW_REPEAT, KW_FOR, KW_IN, KW_LIST, KW_C, KW_PRINT
    };

    // character sets for building random source text
    string letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
    string digits     = "0123456789";
    string blanks     = " \t\n";
    string op_singles = "+-*/,;(){}[]|&^$:=<>!";
    string op_pairs [5] = '{"==", ">=", "<=", "<-", "!="};

    // ------------------------------------------------------------------
    // Scanner model plus the queue of tokens still owed by the block.
    // note_char runs at each accepted character word, check_token at each
    // accepted token word.
    // ------------------------------------------------------------------
    class token_ledger;
        mode_t      mode;
        pend_t      pend;
        logic [7:0] prefix [KW_CHARS];
        int         run_len;
        bit         dot_flag;
        out_word_t  step_tokens [$];
        out_word_t  tokens_due [$];
        int         mismatches;
        int         tokens_seen;

        function new();
            mismatches  = 0;
            tokens_seen = 0;
            clear_token();
        endfunction

        function void clear_token();
            mode     = M_IDLE;
            pend     = P_NONE;
            run_len  = 0;
            dot_flag = 1'b0;
            foreach (prefix[i])
                prefix[i] = 8'h00;
        endfunction

        // at most two tokens per character
        function void emit(logic [5:0] kind, int len);
            out_word_t t;
            if (step_tokens.size() >= 2)
                return;
            t.token_kind   = kind;
            t.token_length = (len > LEN_FIELD_MAX) ? 8'(LEN_FIELD_MAX) : 8'(len);
            t.last         = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function void count_up();
            if (run_len < TOKEN_LEN_MAX)
                run_len++;
        endfunction

        function void add_word_char(logic [7:0] c);
            if (run_len < KW_CHARS)
                prefix[run_len] = c;
            count_up();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_NL;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_word_char(logic [7:0] c);
            return is_letter(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
        endfunction

        function bit is_number_end(logic [7:0] c);
            case (c)
                "+", "*", "-", "<", ">", "/", ";", ")", "}", ",", "]", "^", ":",
                "!", "=": return 1'b1;
                default:  return 1'b0;
            endcase
        endfunction

        function int single_kind(logic [7:0] c);
            case (c)
                "+": return K_PLUS;    "-": return K_MINUS;
                "*": return K_STAR;    "/": return K_SLASH;
                ",": return K_COMMA;   ";": return K_SEMI;
                "(": return K_LPAR;    ")": return K_RPAR;
                "{": return K_LBRACE;  "}": return K_RBRACE;
                "[": return K_LBRACK;  "]": return K_RBRACK;
                "|": return K_PIPE;    "&": return K_AMP;
                "^": return K_CARET;   "$": return K_DOLLAR;
                ":": return K_COLON;
                default: return -1;
            endcase
        endfunction

        function logic [5:0] word_kind();
            int  i;
            int  j;
            int  n;
            bit  hit;
            for (i = 0; i < KW_COUNT; i++) begin
                n   = kw_spelling[i].len();
                hit = (n == run_len) && (n <= KW_CHARS);
                for (j = 0; j < n && hit; j++)
                    if (prefix[j] != kw_spelling[i][j])
                        hit = 1'b0;
                if (hit)
                    return kw_class[i];
            end
            return K_ID;
        endfunction

        // an opener with no second character stands alone
        function logic [5:0] lone_operator();
            case (pend)
                P_EQ:    return K_AFF;
                P_GT:    return K_GT;
                P_LT:    return K_LT;
                P_EXCL:  return K_EXCL;
                default: return K_ERROR;
            endcase
        endfunction

        function void open_token(logic [7:0] c);
            int k;
            clear_token();
            k = single_kind(c);
            if (is_space(c))
                return;
            if (is_letter(c)) begin
                mode = M_WORD;
                add_word_char(c);
            end
            else if (c == CH_DOT)
                mode = M_DOT;
            else if (is_digit(c)) begin
                mode    = M_NUMBER;
                run_len = 1;
            end
            else if (c == CH_HASH)
                mode = M_COMMENT;
            else if (c == CH_QUOTE)
                mode = M_STRING;
            else if (c == CH_EQ || c == CH_GT || c == CH_LT || c == CH_EXCL) begin
                mode = M_OPER;
                pend = (c == CH_EQ) ? P_EQ : (c == CH_GT) ? P_GT :
                       (c == CH_LT) ? P_LT : P_EXCL;
            end
            else if (k >= 0)
                emit(6'(k), 1);
            else begin
                emit(K_ERROR, 1);
                mode = M_SKIP;
            end
        endfunction

        function void scan_byte(logic [7:0] c);
            bit paired;
            case (mode)
                M_WORD: begin
                    if (is_word_char(c))
                        add_word_char(c);
                    else begin
                        emit(word_kind(), run_len);
                        open_token(c);
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c))
                        count_up();
                    else if (c == CH_DOT) begin
                        count_up();
                        if (dot_flag) begin
                            emit(K_ERROR, run_len);
                            clear_token();
                            mode = M_SKIP;
                        end
                        else
                            dot_flag = 1'b1;
                    end
                    else if (is_space(c)) begin
                        emit(K_NUMBER, run_len);
                        clear_token();
                    end
                    else if (is_number_end(c)) begin
                        emit(K_NUMBER, run_len);
                        open_token(c);
                    end
                    else begin
                        emit(K_ERROR, run_len);
                        clear_token();
                        mode = M_SKIP;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit(K_STRING, run_len);
                        clear_token();
                    end
                    else
                        count_up();
                end
                M_COMMENT: begin
                    if (c == CH_NL)
                        clear_token();
                end
                M_SKIP: begin
                    if (is_space(c))
                        clear_token();
                end
                M_DOT: begin
                    if (is_letter(c)) begin
                        clear_token();
                        mode = M_WORD;
                        add_word_char(CH_DOT);
                        add_word_char(c);
                    end
                    else if (is_digit(c)) begin
                        clear_token();
                        mode     = M_NUMBER;
                        dot_flag = 1'b1;
                        run_len  = 2;
                    end
                    else begin
                        emit(K_DOT, 1);
                        open_token(c);
                    end
                end
                M_OPER: begin
                    paired = 1'b1;
                    if (c == CH_EQ && pend == P_EQ)
                        emit(K_EQ, 2);
                    else if (c == CH_EQ && pend == P_GT)
                        emit(K_GE, 2);
                    else if (c == CH_EQ && pend == P_LT)
                        emit(K_LE, 2);
                    else if (c == CH_MINUS && pend == P_LT)
                        emit(K_AFF, 2);
                    else if (c == CH_EQ && pend == P_EXCL)
                        emit(K_DIFF, 2);
                    else
                        paired = 1'b0;
                    if (paired)
                        clear_token();
                    else begin
                        emit(lone_operator(), 1);
                        open_token(c);
                    end
                end
                default: open_token(c);
            endcase
        endfunction

        // end mark: flush the open token, then eof, then back to reset state
        function void close_input();
            case (mode)
                M_WORD:   emit(word_kind(), run_len);
                M_NUMBER: emit(K_NUMBER, run_len);
                M_STRING: emit(K_ERROR, run_len);
                M_DOT:    emit(K_DOT, 1);
                M_OPER:   emit(lone_operator(), 1);
                default:  ;
            endcase
            emit(K_EOF, EOF_LEN);
            clear_token();
        endfunction

        function void note_char(in_word_t w);
            step_tokens.delete();
            if (w.end_of_input)
                close_input();
            else
                scan_byte(w.char_byte);
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i])
                tokens_due.push_back(step_tokens[i]);
        endfunction

        function void check_token(out_word_t got);
            out_word_t want;
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                $error("unexpected token word: kind %0d length %0d last %0d",
                       got.token_kind, got.token_length, got.last);
                mismatches++;
                return;
            end
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                mismatches++;
            end
            if (got.token_length !== want.token_length) begin
                $error("token_length: expected %0d, got %0d",
                       want.token_length, got.token_length);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block itself
    // ------------------------------------------------------------------
    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      char_valid  = 1'b0;
    in_word_t  char_word   = '0;
    logic      token_stall = 1'b0;
    logic      char_stall;
    logic      token_valid;
    out_word_t token_word;

    token_ledger ledger;
    int          chars_sent  = 0;
    int          end_marks   = 0;
    int          token_count = 0;
    bit          idle_on     = 1'b1;   // random gaps and stalls allowed

    always #(HALF_PERIOD) clk = ~clk;

    script_token_scanner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    // ------------------------------------------------------------------
    // Character side. Each call offers one word and returns at the edge
    // that takes it; the stall value read just after the edge is the one
    // the block saw at that edge. An optional gap of idle cycles
    // comes first, so gaps land at every point of the scan.
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_word  <= w;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        ledger.note_char(w);
        chars_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        in_word_t w;
        w.char_byte    = c;
        w.end_of_input = 1'b0;
        send_word(w);
    endtask

    // the byte that rides along with an end mark is ignored, so it is random
    task automatic send_end();
        in_word_t w;
        w.char_byte    = 8'($urandom);
        w.end_of_input = 1'b1;
        end_marks++;
        send_word(w);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // One token of mostly well-formed source, with some noise and broken
    // pieces mixed in. Separators are left out now and then so that tokens
    // butt up against each other and one character closes and opens.
    task automatic send_random_token();
        int         pick;
        int         n;
        bit         go_long;
        logic [7:0] b;
        token_count++;
        // a handful of tokens run past the 255 length saturation
        go_long = (token_count % 150 == 75) || ($urandom_range(0, 299) == 0);
        pick    = $urandom_range(0, 99);
        if (go_long)
            pick = $urandom_range(0, 1) ? 20 : 50;

        if (pick < 18)
            send_text(kw_spelling[$urandom_range(0, KW_COUNT - 1)]);
        else if (pick < 33) begin
            // identifier, sometimes with a leading dot
            if ($urandom_range(0, 4) == 0)
                send_char(CH_DOT);
            send_char(pick_from(letters));
            n = go_long ? $urandom_range(250, 270) : $urandom_range(0, 10);
            repeat (n) send_char(pick_from(word_chars));
        end
        else if (pick < 48) begin
            // number: optional leading dot, optional fraction, rare second dot
            if ($urandom_range(0, 9) == 0)
                send_char(CH_DOT);
            repeat ($urandom_range(1, 5)) send_char(pick_from(digits));
            if ($urandom_range(0, 1) == 0) begin
                send_char(CH_DOT);
                repeat ($urandom_range(0, 4)) send_char(pick_from(digits));
            end
            if ($urandom_range(0, 11) == 0) begin
                send_char(CH_DOT);
                send_char(pick_from(digits));
            end
        end
        else if (pick < 56) begin
            // string with any byte but a quote inside, sometimes left open
            send_char(CH_QUOTE);
            n = go_long ? $urandom_range(250, 270) : $urandom_range(0, 12);
            repeat (n) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE);
                send_char(b);
            end
            if ($urandom_range(0, 9) != 0)
                send_char(CH_QUOTE);
        end
        else if (pick < 60) begin
            send_char(CH_HASH);
            repeat ($urandom_range(0, 8)) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_NL);
                send_char(b);
            end
            if ($urandom_range(0, 9) != 0)
                send_char(CH_NL);
        end
        else if (pick < 80) begin
            case ($urandom_range(0, 2))
                0:       send_char(pick_from(op_singles));
                1:       send_text(op_pairs[$urandom_range(0, 4)]);
                default: send_char(pick_from("=<>!"));
            endcase
        end
        else if (pick < 86)
            send_char(CH_DOT);
        else if (pick < 95)
            send_char(8'($urandom_range(0, 255)));
        else
            send_end();

        if ($urandom_range(0, 9) < 6)
            send_char(pick_from(blanks));
    endtask

    // ------------------------------------------------------------------
    // Token side: takes words, stalls in random bursts, and once holds off
    // for a long stretch so that the queue fills and char_stall rises.
    // ------------------------------------------------------------------
    initial begin : token_sink
        int hold;
        bit long_hold_done;
        hold           = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (token_valid && !token_stall)
                ledger.check_token(token_word);
            if (hold > 0)
                hold--;
            else if (!long_hold_done && chars_sent >= HOLD_AT) begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 18);
            token_stall <= (hold > 0);
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed text, random source, drain, verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        ledger = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword, dot-led word, dot-led number hitting a second
        // dot, the operator text after that error skipped up to whitespace,
        // top-bit bytes as bad characters and as string content, an open
        // string at end mark, a number broken by a letter.
        send_text("if .a.9 .5..<-!=!");
        send_char(8'h00);
        send_char(CH_NL);
        send_char(8'hFF);
        send_char(CH_TAB);
        send_char(CH_QUOTE);
        send_char(8'h80);
        send_end();
        send_text("9a");
        send_end();

        // Random source; idling switches on and off in stretches and is
        // off altogether for the closing part.
        while (chars_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 59) == 0)
                idle_on = !idle_on;
            if (chars_sent > QUIET_FROM)
                idle_on = 1'b0;
            send_random_token();
        end
        send_end();
        char_valid <= 1'b0;

        while (ledger.tokens_due.size() != 0)
            @(posedge clk);
        // anything the block emits past this point is a stray token
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Scanned %0d characters with %0d end marks; %0d tokens checked,",
                 chars_sent, end_marks, ledger.tokens_seen);
        $display("including saturated lengths and a %0d-cycle output hold-off.", LONG_HOLD);
        if (ledger.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/sts_pkg.sv
sv/sts_scan.sv
sv/sts_out_fifo.sv
sv/script_token_scanner.sv
bench/testbench.sv
